// ===== design/hsd_pkg.sv =====
// Shared types, field widths and check-matrix helpers for the Hamming decoder.
// No dependencies; imported by every module of the decoder.

package hsd_pkg;

	localparam int CW_W        = 15;
	localparam int DATA_W      = 11;
	localparam int SYN_W       = 4;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 16;
	localparam int M_TUSER_W   = 2;
	localparam int MAX_CHK     = 6;
	localparam int MAX_LEN     = 63;

	typedef struct packed {
		logic uncorrectable;
		logic corrected;
	} hsd_flags_t;

	function automatic int hsd_popcount(input logic [MAX_CHK-1:0] v);
		int n;
		n = 0;
		for (int b = 0; b < MAX_CHK; b++) begin
			n = n + int'(v[b]);
		end
		return n;
	endfunction

	// Row idx of the transposed check matrix: multi-bit indices first, then powers of two.
	function automatic logic [MAX_CHK-1:0] hsd_row_value(input int idx, input int n,
		input int c);
		int k;
		logic [MAX_CHK-1:0] cmask;
		logic [MAX_CHK-1:0] m;
		logic [MAX_CHK-1:0] r;
		k = 0;
		r = '0;
		cmask = MAX_CHK'((1 << c) - 1);
		for (int v = 1; v <= MAX_LEN; v++) begin
			if (v <= n) begin
				m = MAX_CHK'(v) & cmask;
				if (hsd_popcount(m) > 1) begin
					if (k == idx) r = m;
					k = k + 1;
				end
			end
		end
		for (int v = 1; v <= MAX_LEN; v++) begin
			if (v <= n) begin
				m = MAX_CHK'(v) & cmask;
				if (hsd_popcount(m) <= 1) begin
					if (k == idx) r = m;
					k = k + 1;
				end
			end
		end
		return r;
	endfunction

	// Number of information positions that reach the data field.
	function automatic int hsd_flip_len(input int n, input int c);
		int d;
		d = (n > c) ? n - c : 0;
		return (d < DATA_W) ? d : DATA_W;
	endfunction

endpackage

// ===== design/hsd_syndrome.sv =====
// Stage 1 of the decoder: syndrome of the received word against the check matrix.
// Depends on hsd_pkg.

module hsd_syndrome import hsd_pkg::*; #(
	parameter int CODE_LENGTH = 15,
	parameter int CHECK_BITS  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CW_W-1:0]       in_cw,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_W-1:0]     out_data,
	output logic [CHECK_BITS-1:0] out_syn
);

	localparam int NSYN = (CODE_LENGTH < CW_W) ? CODE_LENGTH : CW_W;

	logic [CHECK_BITS-1:0] row [NSYN];
	logic [CHECK_BITS-1:0] syn;
	logic                  valid_s1;
	logic [DATA_W-1:0]     data_s1;
	logic [CHECK_BITS-1:0] syn_s1;

	for (genvar g = 0; g < NSYN; g++) begin : g_row
		localparam logic [MAX_CHK-1:0] RV = hsd_row_value(g, CODE_LENGTH, CHECK_BITS);
		assign row[g] = RV[CHECK_BITS-1:0];
	end

	always_comb begin
		syn = '0;
		for (int i = 0; i < NSYN; i++) begin
			if (in_cw[i]) syn = syn ^ row[i];
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_cw[DATA_W-1:0];
			syn_s1  <= syn;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;
	assign out_syn   = syn_s1;

endmodule

// ===== design/hsd_locate.sv =====
// Stage 2 of the decoder: match the syndrome to a matrix row and build the flip mask.
// Depends on hsd_pkg.

module hsd_locate import hsd_pkg::*; #(
	parameter int CODE_LENGTH = 15,
	parameter int CHECK_BITS  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_W-1:0]     in_data,
	input  logic [CHECK_BITS-1:0] in_syn,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_W-1:0]     out_data,
	output logic [DATA_W-1:0]     out_flip,
	output logic [CHECK_BITS-1:0] out_syn,
	output hsd_flags_t            out_flags
);

	localparam int NFLIP = hsd_flip_len(CODE_LENGTH, CHECK_BITS);

	logic [CHECK_BITS-1:0]  row [CODE_LENGTH];
	logic [CODE_LENGTH-1:0] hit;
	logic [DATA_W-1:0]      flip;
	logic                   seen;
	hsd_flags_t             flags;
	logic                   valid_s2;
	logic [DATA_W-1:0]      data_s2;
	logic [DATA_W-1:0]      flip_s2;
	logic [CHECK_BITS-1:0]  syn_s2;
	hsd_flags_t             flags_s2;

	for (genvar g = 0; g < CODE_LENGTH; g++) begin : g_row
		localparam logic [MAX_CHK-1:0] RV = hsd_row_value(g, CODE_LENGTH, CHECK_BITS);
		assign row[g] = RV[CHECK_BITS-1:0];
		assign hit[g] = (in_syn != '0) && (row[g] == in_syn);
	end

	always_comb begin
		flip = '0;
		seen = 1'b0;
		for (int i = 0; i < NFLIP; i++) begin
			flip[i] = hit[i] && !seen;
			seen    = seen || hit[i];
		end
		flags.corrected     = |hit;
		flags.uncorrectable = (in_syn != '0) && !(|hit);
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2  <= in_data;
			flip_s2  <= flip;
			syn_s2   <= in_syn;
			flags_s2 <= flags;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;
	assign out_flip  = flip_s2;
	assign out_syn   = syn_s2;
	assign out_flags = flags_s2;

endmodule

// ===== design/hsd_correct.sv =====
// Stage 3 of the decoder: apply the flip mask, trim the data field, hold the output beat.
// Depends on hsd_pkg.

module hsd_correct import hsd_pkg::*; #(
	parameter int CODE_LENGTH = 15,
	parameter int CHECK_BITS  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_W-1:0]     in_data,
	input  logic [DATA_W-1:0]     in_flip,
	input  logic [CHECK_BITS-1:0] in_syn,
	input  hsd_flags_t            in_flags,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_W-1:0]     out_data,
	output logic [SYN_W-1:0]      out_syn,
	output hsd_flags_t            out_flags
);

	localparam int NFLIP = hsd_flip_len(CODE_LENGTH, CHECK_BITS);

	logic [DATA_W-1:0] data_n;
	logic [SYN_W-1:0]  syn_n;
	logic              valid_s3;
	logic [DATA_W-1:0] data_s3;
	logic [SYN_W-1:0]  syn_s3;
	hsd_flags_t        flags_s3;

	always_comb begin
		data_n = '0;
		for (int i = 0; i < NFLIP; i++) begin
			data_n[i] = in_data[i] ^ in_flip[i];
		end
	end

	if (CHECK_BITS >= SYN_W) begin : g_syn_trim
		assign syn_n = in_syn[SYN_W-1:0];
	end else begin : g_syn_ext
		assign syn_n = SYN_W'(in_syn);
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3  <= data_n;
			syn_s3   <= syn_n;
			flags_s3 <= in_flags;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;
	assign out_syn   = syn_s3;
	assign out_flags = flags_s3;

endmodule

// ===== design/systematic_hamming_decoder.sv =====
// Systematic Hamming single-error decoder, three register stages.
// Throughput: one codeword per cycle; the syndrome XOR, the row match and the correction
// each take one stage, and a stall holds every occupied stage without loss.
// Reset: arst_n clears the stage valid bits; payload registers are not reset.
// Depends on hsd_pkg, hsd_syndrome, hsd_locate and hsd_correct.

module systematic_hamming_decoder import hsd_pkg::*; #(
	parameter int CODE_LENGTH = 15,
	parameter int CHECK_BITS  = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // codeword[14:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // data_bits[10:0], syndrome[14:11]
	output logic [M_TUSER_W-1:0] m_tuser    // corrected[0], uncorrectable[1]
);

	localparam int PAD_W = M_TDATA_W - DATA_W - SYN_W;

	logic                  v1;
	logic                  r1;
	logic [DATA_W-1:0]     data1;
	logic [CHECK_BITS-1:0] syn1;
	logic                  v2;
	logic                  r2;
	logic [DATA_W-1:0]     data2;
	logic [DATA_W-1:0]     flip2;
	logic [CHECK_BITS-1:0] syn2;
	hsd_flags_t            flags2;
	logic [DATA_W-1:0]     data3;
	logic [SYN_W-1:0]      syn3;
	hsd_flags_t            flags3;

	hsd_syndrome #(
		.CODE_LENGTH(CODE_LENGTH),
		.CHECK_BITS (CHECK_BITS)
	) u_syndrome (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cw    (s_tdata[CW_W-1:0]),
		.out_valid(v1),
		.out_ready(r1),
		.out_data (data1),
		.out_syn  (syn1)
	);

	hsd_locate #(
		.CODE_LENGTH(CODE_LENGTH),
		.CHECK_BITS (CHECK_BITS)
	) u_locate (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v1),
		.in_ready (r1),
		.in_data  (data1),
		.in_syn   (syn1),
		.out_valid(v2),
		.out_ready(r2),
		.out_data (data2),
		.out_flip (flip2),
		.out_syn  (syn2),
		.out_flags(flags2)
	);

	hsd_correct #(
		.CODE_LENGTH(CODE_LENGTH),
		.CHECK_BITS (CHECK_BITS)
	) u_correct (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v2),
		.in_ready (r2),
		.in_data  (data2),
		.in_flip  (flip2),
		.in_syn   (syn2),
		.in_flags (flags2),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (data3),
		.out_syn  (syn3),
		.out_flags(flags3)
	);

	assign m_tdata = {{PAD_W{1'b0}}, syn3, data3};
	assign m_tuser = {flags3.uncorrectable, flags3.corrected};

endmodule

// ===== design/hsd_checker.sv =====
// Port-level checks for the Hamming decoder, attached to the top level by bind.
// Depends on hsd_pkg and systematic_hamming_decoder.

module hsd_checker import hsd_pkg::*; #(
	parameter int CODE_LENGTH = 15,
	parameter int CHECK_BITS  = 4
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	localparam bit SYN_FULL = (CHECK_BITS <= SYN_W);
	localparam bit PERFECT  = (CODE_LENGTH == (1 << CHECK_BITS) - 1);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("corrected and uncorrectable both set");

	a_zero_syn: assert property (@(posedge clk) disable iff (!arst_n)
		SYN_FULL && m_tvalid && (m_tdata[DATA_W +: SYN_W] == '0) |-> (m_tuser == '0))
		else $error("flag raised with zero syndrome");

	a_perfect: assert property (@(posedge clk) disable iff (!arst_n)
		PERFECT && m_tvalid |-> !m_tuser[1])
		else $error("uncorrectable flagged on a perfect code");

endmodule

bind systematic_hamming_decoder hsd_checker #(
	.CODE_LENGTH(CODE_LENGTH),
	.CHECK_BITS (CHECK_BITS)
) u_hsd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// ===== tb/hamming_decode_checker.sv =====
// Watches both streams of the Hamming decoder, predicts every decoded beat and compares it.
// Depends on hsd_pkg; instantiated by testbench beside the decoder.

module hamming_decode_checker import hsd_pkg::*; #(
	parameter int CODE_LENGTH = 15,
	parameter int CHECK_BITS  = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic [M_TUSER_W-1:0] m_tuser,
	output int                   mismatches,
	output int                   outstanding,
	output int                   decoded,
	output int                   repaired,
	output int                   clean_words
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [DATA_W-1:0] data_bits;
		logic [SYN_W-1:0]  syndrome;
		hsd_flags_t        flags;
	} decode_t;

	logic [SYN_W-1:0] check_row [CW_W];
	decode_t          pending_decodes [$];

	initial begin
		int k;
		int masked;
		k = 0;
		for (int v = 1; v <= CODE_LENGTH; v++) begin
			masked = v & ((1 << CHECK_BITS) - 1);
			if ($countones(masked) > 1 && k < CW_W) begin
				check_row[k] = SYN_W'(masked);
				k++;
			end
		end
		for (int v = 1; v <= CODE_LENGTH; v++) begin
			masked = v & ((1 << CHECK_BITS) - 1);
			if ($countones(masked) <= 1 && k < CW_W) begin
				check_row[k] = SYN_W'(masked);
				k++;
			end
		end
	end

	function automatic decode_t decode_word(input logic [CW_W-1:0] cw);
		decode_t          d;
		logic [SYN_W-1:0] s;
		logic [CW_W-1:0]  fixed_cw;
		s = '0;
		for (int i = 0; i < CW_W; i++) begin
			if (cw[i]) s ^= check_row[i];
		end
		fixed_cw = cw;
		d.flags = '0;
		if (s != '0) begin
			for (int i = 0; i < CW_W; i++) begin
				if (!d.flags.corrected && check_row[i] == s) begin
					fixed_cw[i] = ~fixed_cw[i];
					d.flags.corrected = 1'b1;
				end
			end
			d.flags.uncorrectable = !d.flags.corrected;
		end
		d.data_bits = fixed_cw[DATA_W-1:0];
		d.syndrome = s;
		return d;
	endfunction

	task automatic flag_field(input string field, input logic [15:0] want_v, got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %h, actual %h", $time, field, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		decode_t want;
		decode_t got;
		if (!arst_n) begin
			pending_decodes.delete();
			mismatches = 0;
			outstanding = 0;
			decoded = 0;
			repaired = 0;
			clean_words = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.data_bits = m_tdata[DATA_W-1:0];
				got.syndrome = m_tdata[DATA_W +: SYN_W];
				got.flags = m_tuser;
				if (pending_decodes.size() == 0) begin
					$display("%0t: beat with nothing expected, expected none, actual %h/%h",
						$time, m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = pending_decodes.pop_front();
					flag_field("data_bits", 16'(want.data_bits), 16'(got.data_bits));
					flag_field("syndrome", 16'(want.syndrome), 16'(got.syndrome));
					flag_field("corrected", 16'(want.flags.corrected),
						16'(got.flags.corrected));
					flag_field("uncorrectable", 16'(want.flags.uncorrectable),
						16'(got.flags.uncorrectable));
					decoded++;
				end
			end
			if (s_tvalid && s_tready) begin
				want = decode_word(s_tdata[CW_W-1:0]);
				pending_decodes.push_back(want);
				if (want.flags.corrected) repaired++;
				if (want.syndrome == '0) clean_words++;
			end
			outstanding = pending_decodes.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the Hamming decoder testbench: clock, reset, codeword stimulus and verdict.
// Depends on hsd_pkg, systematic_hamming_decoder and hamming_decode_checker.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import hsd_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	int mismatches;
	int outstanding;
	int decoded;
	int repaired;
	int clean_words;
	int sent = 0;

	systematic_hamming_decoder #(
		.CODE_LENGTH(15),
		.CHECK_BITS (4)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	hamming_decode_checker #(
		.CODE_LENGTH(15),
		.CHECK_BITS (4)
	) CHK (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.outstanding(outstanding),
		.decoded    (decoded),
		.repaired   (repaired),
		.clean_words(clean_words)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit burst_phase();
		return sent >= 700 && sent < 850;
	endfunction

	function automatic int idle_span(input int shortest);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return shortest;
		if (r < 93) return $urandom_range(shortest + 1, 4);
		return $urandom_range(12, 40);
	endfunction

	function automatic logic [CW_W-1:0] encode_word(input logic [DATA_W-1:0] data);
		logic [SYN_W-1:0] parity;
		int k;
		parity = '0;
		k = 0;
		for (int v = 1; v <= CW_W; v++) begin
			if ($countones(v) > 1) begin
				if (data[k]) parity ^= SYN_W'(v);
				k++;
			end
		end
		return {parity, data};
	endfunction

	function automatic logic [CW_W-1:0] with_errors(input logic [CW_W-1:0] cw, input int n);
		int p;
		for (int e = 0; e < n; e++) begin
			p = $urandom_range(0, CW_W - 1);
			cw[p] = ~cw[p];
		end
		return cw;
	endfunction

	task automatic send_word(input logic [CW_W-1:0] cw);
		int gap;
		gap = burst_phase() ? 0 : idle_span(0);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'(cw);
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Receiver: random stalls, one long hold-off to back up the pipeline.
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			if (!held && sent >= 300) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (150) @(posedge clk);
			end else if (burst_phase() || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat (idle_span(1)) @(posedge clk);
			end
		end
	end

	initial begin
		logic [CW_W-1:0] base;
		logic [CW_W-1:0] cw;
		int pick;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		base = encode_word(DATA_W'($urandom));
		send_word('0);
		send_word('1);
		send_word(encode_word('1));
		send_word(base);
		for (int p = 0; p < CW_W; p++) begin
			send_word(base ^ (CW_W'(1) << p));
		end
		send_word(base ^ CW_W'(3));
		send_word(base ^ CW_W'(15'h4801));
		send_word(encode_word('1) ^ (CW_W'(1) << (CW_W - 1)));

		for (int n = 0; n < 1250; n++) begin
			pick = $urandom_range(0, 9);
			cw = encode_word(DATA_W'($urandom));
			if (pick >= 4 && pick < 7) cw = with_errors(cw, 1);
			else if (pick == 7) cw = with_errors(cw, 2);
			else if (pick > 7) cw = CW_W'($urandom_range(0, 32767));
			send_word(cw);
		end
		s_tvalid <= 1'b0;

		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		$display("%0d codewords sent, %0d decoded beats checked", sent, decoded);
		$display("%0d single-bit repairs, %0d zero syndromes", repaired, clean_words);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

endmodule
